### rtl/generational_slot_allocator_defines.svh
// Assertion macros for the generational slot allocator.
// ASSERT_IMP: same-cycle implication. ASSERT_NXT: next-cycle implication.
`ifndef GENERATIONAL_SLOT_ALLOCATOR_DEFINES_SVH
`define GENERATIONAL_SLOT_ALLOCATOR_DEFINES_SVH

`ifndef SYNTHESIS

`define ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("assertion failed");

`define ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("assertion failed");

`else

`define ASSERT_IMP(label, clk, rst_n, ante, cons)
`define ASSERT_NXT(label, clk, rst_n, ante, cons)

`endif

`endif

### rtl/gsa_pkg.sv
`default_nettype none

package gsa_pkg;

	localparam int unsigned SLOT_COUNT_DEF = 256;
	localparam int unsigned GEN_BITS_DEF   = 16;

	// request kinds
	localparam logic [1:0] FUNC_ALLOC  = 2'd0;
	localparam logic [1:0] FUNC_FREE   = 2'd1;
	localparam logic [1:0] FUNC_LOOKUP = 2'd2;

	// result status codes
	localparam logic [1:0] STAT_OK   = 2'd0;
	localparam logic [1:0] STAT_FULL = 2'd1;
	localparam logic [1:0] STAT_BAD  = 2'd2;

	typedef struct packed {
		logic [1:0]  func;
		logic [7:0]  handle_index;
		logic [15:0] handle_generation;
	} req_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [7:0]  slot_index;
		logic [15:0] slot_generation;
	} rsp_t;

endpackage

`default_nettype wire

### rtl/generational_slot_allocator.sv
`default_nettype none
// Channel   | Ports                  | Handshake
// ----------+------------------------+-------------------------------------
// request   | start, busy, req       | taken at a clock edge with start & !busy
// result    | done, rsp              | one-cycle strobe, cannot be stalled
//
// States: a free, a lookup or an allocate that finds the free stack empty
//   holds busy through READ and EVAL after acceptance; an allocate that
//   pops the free stack holds busy through READ, POP and EVAL. POP exists
//   because both memories return read data through a register: the
//   stack read must finish before the slot read it addresses.
// Result: done pulses the cycle after the evaluation cycle; a new request
//   may be accepted in that same cycle.
// Reset: no clearing pass. used_mark serves as a fill mark, so slot entries
//   at or above it are never used; stack data is only used where written.
// Stalls: none on the result side; the requester waits on busy.

`include "generational_slot_allocator_defines.svh"

module generational_slot_allocator #(
	parameter int unsigned SLOT_COUNT = gsa_pkg::SLOT_COUNT_DEF,
	parameter int unsigned GEN_BITS   = gsa_pkg::GEN_BITS_DEF
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	output      logic          busy,
	input  wire gsa_pkg::req_t req,
	output      logic          done,
	output      gsa_pkg::rsp_t rsp
);

	localparam int unsigned IDX_W = $clog2(SLOT_COUNT);
	localparam int unsigned CNT_W = $clog2(SLOT_COUNT + 1);
	localparam int unsigned CMP_W = (CNT_W > 8) ? CNT_W : 8;
	localparam int unsigned GW    = (GEN_BITS > 16) ? GEN_BITS : 16;
	localparam int unsigned SW    = GEN_BITS + 1;    // {alive, generation}

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_READ = 4'b0010,    // stack top and handle slot being read
		ST_POP  = 4'b0100,    // popped index back; slot being read
		ST_EVAL = 4'b1000     // slot word back; decide and write back
	} state_t;

	state_t              state_q, state_d;
	gsa_pkg::req_t       req_q;
	logic [CNT_W-1:0]    free_count_q;
	logic [CNT_W-1:0]    used_mark_q;
	logic                done_q;
	gsa_pkg::rsp_t       rsp_q, rsp_d;

	// memories
	logic [SW-1:0]       slot_mem [SLOT_COUNT];
	logic [IDX_W-1:0]    stk_mem  [SLOT_COUNT];
	logic [SW-1:0]       slot_rd_q;
	logic [IDX_W-1:0]    stk_rd_q;

	logic                slot_re, stk_re;
	logic [IDX_W-1:0]    slot_raddr, stk_raddr;
	logic                slot_we, stk_we;
	logic [IDX_W-1:0]    slot_waddr, stk_waddr;
	logic [SW-1:0]       slot_wdata;
	logic                fc_inc, fc_dec, um_inc;

	logic [CMP_W-1:0]    idx_ext, used_ext, new_ext;
	logic [IDX_W-1:0]    h_addr, new_slot;
	logic [CNT_W-1:0]    fc_m1;
	logic [GEN_BITS-1:0] cur_gen, inc_gen;
	logic [GW-1:0]       cur_gen_x, inc_gen_x;
	logic                cur_alive, handle_ok, stack_has, table_full;

	assign idx_ext    = CMP_W'(req_q.handle_index);
	assign used_ext   = CMP_W'(used_mark_q);
	assign h_addr     = idx_ext[IDX_W-1:0];
	assign fc_m1      = free_count_q - CNT_W'(1);
	assign stack_has  = (free_count_q != '0);
	assign table_full = (used_mark_q == CNT_W'(SLOT_COUNT));

	assign cur_alive  = slot_rd_q[GEN_BITS];
	assign cur_gen    = slot_rd_q[GEN_BITS-1:0];
	assign inc_gen    = cur_gen + GEN_BITS'(1);    // wraps
	assign cur_gen_x  = GW'(cur_gen);
	assign inc_gen_x  = GW'(inc_gen);

	// slot_rd_q holds the handle's slot whenever EVAL follows READ directly
	assign handle_ok  = (idx_ext < used_ext) && cur_alive
		&& (cur_gen_x[15:0] == req_q.handle_generation);

	// next state and read issue
	always_comb begin
		state_d    = state_q;
		slot_re    = 1'b0;
		stk_re     = 1'b0;
		slot_raddr = h_addr;
		stk_raddr  = fc_m1[IDX_W-1:0];
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					state_d = ST_READ;
				end
			end
			ST_READ: begin
				slot_re = 1'b1;
				stk_re  = 1'b1;
				if (req_q.func == gsa_pkg::FUNC_ALLOC && stack_has) begin
					state_d = ST_POP;
				end else begin
					state_d = ST_EVAL;
				end
			end
			ST_POP: begin
				slot_re    = 1'b1;
				slot_raddr = stk_rd_q;
				state_d    = ST_EVAL;
			end
			ST_EVAL: begin
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// evaluation and write-back
	always_comb begin
		slot_we    = 1'b0;
		stk_we     = 1'b0;
		slot_waddr = h_addr;
		slot_wdata = {1'b0, inc_gen};
		stk_waddr  = free_count_q[IDX_W-1:0];
		fc_inc     = 1'b0;
		fc_dec     = 1'b0;
		um_inc     = 1'b0;
		new_slot   = used_mark_q[IDX_W-1:0];
		new_ext    = CMP_W'(stk_rd_q);
		rsp_d.status          = gsa_pkg::STAT_BAD;
		rsp_d.slot_index      = req_q.handle_index;
		rsp_d.slot_generation = '0;
		if (state_q == ST_EVAL) begin
			case (req_q.func)
				gsa_pkg::FUNC_ALLOC: begin
					if (stack_has) begin
						// reuse most recently freed slot, generation kept
						slot_we    = 1'b1;
						slot_waddr = stk_rd_q;
						slot_wdata = {1'b1, cur_gen};
						fc_dec     = 1'b1;
						rsp_d.status          = gsa_pkg::STAT_OK;
						rsp_d.slot_index      = new_ext[7:0];
						rsp_d.slot_generation = cur_gen_x[15:0];
					end else if (!table_full) begin
						// never-used slot: generation is zero
						new_ext    = CMP_W'(used_mark_q);
						slot_we    = 1'b1;
						slot_waddr = new_slot;
						slot_wdata = {1'b1, GEN_BITS'(0)};
						um_inc     = 1'b1;
						rsp_d.status          = gsa_pkg::STAT_OK;
						rsp_d.slot_index      = new_ext[7:0];
						rsp_d.slot_generation = '0;
					end else begin
						rsp_d.status     = gsa_pkg::STAT_FULL;
						rsp_d.slot_index = '0;
					end
				end
				gsa_pkg::FUNC_FREE: begin
					if (handle_ok && free_count_q != CNT_W'(SLOT_COUNT)) begin
						slot_we = 1'b1;
						stk_we  = 1'b1;
						fc_inc  = 1'b1;
						rsp_d.status          = gsa_pkg::STAT_OK;
						rsp_d.slot_generation = inc_gen_x[15:0];
					end
				end
				gsa_pkg::FUNC_LOOKUP: begin
					if (handle_ok) begin
						rsp_d.status          = gsa_pkg::STAT_OK;
						rsp_d.slot_generation = cur_gen_x[15:0];
					end
				end
				default: begin
					rsp_d.status = gsa_pkg::STAT_BAD;
				end
			endcase
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			free_count_q <= '0;
			used_mark_q  <= '0;
			done_q       <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= (state_q == ST_EVAL);
			if (fc_inc) begin
				free_count_q <= free_count_q + CNT_W'(1);
			end else if (fc_dec) begin
				free_count_q <= fc_m1;
			end
			if (um_inc) begin
				used_mark_q <= used_mark_q + CNT_W'(1);
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && start) begin
			req_q <= req;
		end
		if (state_q == ST_EVAL) begin
			rsp_q <= rsp_d;
		end
	end

	// slot memory: alive bit and generation
	always_ff @(posedge clk) begin
		if (slot_we) begin
			slot_mem[slot_waddr] <= slot_wdata;
		end
		if (slot_re) begin
			slot_rd_q <= slot_mem[slot_raddr];
		end
	end

	// free stack memory
	always_ff @(posedge clk) begin
		if (stk_we) begin
			stk_mem[stk_waddr] <= h_addr;
		end
		if (stk_re) begin
			stk_rd_q <= stk_mem[stk_raddr];
		end
	end

	assign busy = (state_q != ST_IDLE);
	assign done = done_q;
	assign rsp  = rsp_q;

	// every evaluation produces exactly one result strobe
	`ASSERT_NXT(a_eval_done, clk, arst_n, state_q == ST_EVAL, done)
	// the free stack never holds more entries than slots handed out
	`ASSERT_IMP(a_stack_bound, clk, arst_n, 1'b1, free_count_q <= used_mark_q)
	// a full report means every slot was handed out and none is free
	`ASSERT_IMP(a_full_exact, clk, arst_n, done && rsp.status == gsa_pkg::STAT_FULL,
		table_full && !stack_has)

endmodule

`default_nettype wire
